[rtl/assert_macros.svh]
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

[rtl/ble_dcs_pkg.sv]
// Types and constants for the BLE data channel selection block.
package ble_dcs_pkg;

    localparam int NUM_CH     = 37;
    localparam int MAP_W      = NUM_CH;
    localparam int CNT_W      = 16;
    localparam int CH_W       = 6;
    localparam int HOP_W      = 5;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;
    localparam int STEP_W     = 3;

    localparam logic [HOP_W-1:0] HOP_RESET = HOP_W'(5);
    localparam logic [CH_W-1:0]  LAST_CH   = CH_W'(NUM_CH - 1);
    localparam logic [CH_W-1:0]  NUM_CH_V  = CH_W'(NUM_CH);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CH_W - 1);
    localparam logic [CNT_W-1:0] CNT_RESET = '1;
    localparam logic [MAP_W-1:0] MAP_ALL   = '1;

    typedef enum logic [1:0] {
        ACT_QUEUE   = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_START   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_COUNT,
        ST_DIV,
        ST_FIND,
        ST_OUT
    } dcs_state_t;

endpackage

[rtl/ble_data_channel_select.sv]
// Top level: BLE data channel selection (algorithm #1), bit-serial datapath.
//
// Channel   Signals                                   Contents
// ------    ---------------------------------------   ------------------------------
// input     s_axis_tvalid/tready/tdata/tuser           map update, advance, start
// output    m_axis_tvalid/tready/tdata                 one result word per event
// config    cfg_valid/cfg_ready/cfg_data               hop increment
//
// An advance or start holds the input while the block accepts the word, steps the
// counter and channel, counts used channels in one scan, works out the remainder,
// finds the remapped channel in a second scan and loads the output register. If the
// hopped channel is in use or the map is empty, the remainder and second scan are
// skipped. A map update is taken in idle. Reset clears the control state at once.
// A result waits in the output register while the next word is taken; a later one
// stalls in its last cycle until the waiting word has been taken.
`include "assert_macros.svh"

module ble_data_channel_select (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: new_map[36:0], instant[52:37], zero fill to 56 bits
    input  logic [ble_dcs_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: event_counter[15:0], hop_channel[21:16], data_channel[27:22],
    //        map_applied[28], no_channel[29], zero fill to 32 bits
    output logic [31:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    ble_dcs_pkg::dcs_state_t state_reg, state_next;

    logic [ble_dcs_pkg::HOP_W-1:0] hop_reg, hop_next;
    logic [ble_dcs_pkg::MAP_W-1:0] cur_map_reg, cur_map_next;
    logic [ble_dcs_pkg::MAP_W-1:0] pend_map_reg, pend_map_next;
    logic [ble_dcs_pkg::CNT_W-1:0] pend_inst_reg, pend_inst_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [ble_dcs_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [ble_dcs_pkg::CH_W-1:0]  unm_reg, unm_next;
    logic                          m_valid_reg, m_valid_next;

    logic [ble_dcs_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic                          applied_reg, applied_next;
    logic [ble_dcs_pkg::CH_W-1:0]  idx_reg, idx_next;
    logic [ble_dcs_pkg::CH_W-1:0]  used_reg, used_next;
    logic                          hit_reg, hit_next;
    logic [ble_dcs_pkg::CH_W-1:0]  rem_reg, rem_next;
    logic [ble_dcs_pkg::CH_W-1:0]  dvd_reg, dvd_next;
    logic [ble_dcs_pkg::STEP_W-1:0] step_reg, step_next;
    logic [ble_dcs_pkg::CH_W-1:0]  seen_reg, seen_next;
    logic [ble_dcs_pkg::CH_W-1:0]  found_ch_reg, found_ch_next;
    logic                          found_reg, found_next;

    logic                          in_fire;
    logic                          out_load;
    logic                          map_bit;
    logic                          scan_last;
    logic [ble_dcs_pkg::CH_W-1:0]  used_acc;
    logic                          hit_acc;
    logic [ble_dcs_pkg::CNT_W-1:0] cnt_inc;
    logic [ble_dcs_pkg::CH_W:0]    hop_sum;
    logic [ble_dcs_pkg::CH_W:0]    trial;
    logic [ble_dcs_pkg::CH_W-1:0]  data_ch;
    logic                          none;

    assign s_axis_tready = (state_reg == ble_dcs_pkg::ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == ble_dcs_pkg::ST_OUT) && (!m_valid_reg || m_axis_tready);
    assign map_bit   = cur_map_reg[0];
    assign scan_last = (idx_reg == ble_dcs_pkg::LAST_CH);
    assign used_acc  = used_reg + ble_dcs_pkg::CH_W'(map_bit);
    assign hit_acc   = hit_reg || (map_bit && (idx_reg == unm_reg));
    assign cnt_inc   = cnt_reg + 1'b1;
    assign hop_sum   = {1'b0, unm_reg} + (ble_dcs_pkg::CH_W+1)'(hop_reg);
    assign trial     = {rem_reg, dvd_reg[ble_dcs_pkg::CH_W-1]};

    // The data channel is only chosen by the second scan when the unmapped
    // channel itself is not in use.
    assign none    = (used_reg == '0);
    assign data_ch = none ? '0 : (hit_reg ? unm_reg : found_ch_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ble_dcs_pkg::ST_IDLE:
            begin
                if (in_fire && ((s_axis_tuser == ble_dcs_pkg::ACT_ADVANCE) ||
                                (s_axis_tuser == ble_dcs_pkg::ACT_START)))
                begin
                    state_next = ble_dcs_pkg::ST_ADV;
                end
            end
            ble_dcs_pkg::ST_ADV:
            begin
                state_next = ble_dcs_pkg::ST_COUNT;
            end
            ble_dcs_pkg::ST_COUNT:
            begin
                if (scan_last)
                begin
                    if ((used_acc == '0) || hit_acc)
                    begin
                        state_next = ble_dcs_pkg::ST_OUT;
                    end
                    else
                    begin
                        state_next = ble_dcs_pkg::ST_DIV;
                    end
                end
            end
            ble_dcs_pkg::ST_DIV:
            begin
                if (step_reg == ble_dcs_pkg::LAST_STEP)
                begin
                    state_next = ble_dcs_pkg::ST_FIND;
                end
            end
            ble_dcs_pkg::ST_FIND:
            begin
                if (scan_last)
                begin
                    state_next = ble_dcs_pkg::ST_OUT;
                end
            end
            ble_dcs_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ble_dcs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ble_dcs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        hop_next        = hop_reg;
        cur_map_next    = cur_map_reg;
        pend_map_next   = pend_map_reg;
        pend_inst_next  = pend_inst_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        unm_next        = unm_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        applied_next    = applied_reg;
        idx_next        = idx_reg;
        used_next       = used_reg;
        hit_next        = hit_reg;
        rem_next        = rem_reg;
        dvd_next        = dvd_reg;
        step_next       = step_reg;
        seen_next       = seen_reg;
        found_ch_next   = found_ch_reg;
        found_next      = found_reg;

        if (cfg_valid && cfg_ready)
        begin
            hop_next = cfg_data;
        end

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ble_dcs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (ble_dcs_pkg::action_t'(s_axis_tuser))
                        ble_dcs_pkg::ACT_QUEUE:
                        begin
                            pend_map_next   = s_axis_tdata[36:0];
                            pend_inst_next  = s_axis_tdata[52:37];
                            pend_valid_next = 1'b1;
                        end
                        ble_dcs_pkg::ACT_START:
                        begin
                            cur_map_next    = s_axis_tdata[36:0];
                            pend_valid_next = 1'b0;
                            cnt_next        = ble_dcs_pkg::CNT_RESET;
                            unm_next        = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ble_dcs_pkg::ST_ADV:
            begin
                cnt_next     = cnt_inc;
                applied_next = 1'b0;
                if (pend_valid_reg && (pend_inst_reg == cnt_inc))
                begin
                    cur_map_next    = pend_map_reg;
                    pend_valid_next = 1'b0;
                    applied_next    = 1'b1;
                end
                if (hop_sum >= (ble_dcs_pkg::CH_W+1)'(ble_dcs_pkg::NUM_CH))
                begin
                    unm_next = ble_dcs_pkg::CH_W'(hop_sum -
                               (ble_dcs_pkg::CH_W+1)'(ble_dcs_pkg::NUM_CH));
                end
                else
                begin
                    unm_next = hop_sum[ble_dcs_pkg::CH_W-1:0];
                end
                idx_next = '0;
                used_next = '0;
                hit_next = 1'b0;
            end
            ble_dcs_pkg::ST_COUNT:
            begin
                // The map rotates one bit a cycle and is whole again at the end of the scan.
                cur_map_next = {map_bit, cur_map_reg[ble_dcs_pkg::MAP_W-1:1]};
                used_next    = used_acc;
                hit_next     = hit_acc;
                idx_next     = scan_last ? '0 : idx_reg + 1'b1;
                rem_next     = '0;
                dvd_next     = unm_reg;
                step_next    = '0;
            end
            ble_dcs_pkg::ST_DIV:
            begin
                // Restoring division, one quotient bit a cycle; only the
                // remainder is kept.
                if (trial >= {1'b0, used_reg})
                begin
                    rem_next = ble_dcs_pkg::CH_W'(trial - {1'b0, used_reg});
                end
                else
                begin
                    rem_next = trial[ble_dcs_pkg::CH_W-1:0];
                end
                dvd_next   = {dvd_reg[ble_dcs_pkg::CH_W-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                seen_next  = '0;
                found_next = 1'b0;
                idx_next   = '0;
            end
            ble_dcs_pkg::ST_FIND:
            begin
                cur_map_next = {map_bit, cur_map_reg[ble_dcs_pkg::MAP_W-1:1]};
                idx_next     = scan_last ? '0 : idx_reg + 1'b1;
                if (map_bit && !found_reg)
                begin
                    if (seen_reg == rem_reg)
                    begin
                        found_next    = 1'b1;
                        found_ch_next = idx_reg;
                    end
                    seen_next = seen_reg + 1'b1;
                end
            end
            ble_dcs_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, none, applied_reg, data_ch, unm_reg, cnt_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ble_dcs_pkg::ST_IDLE;
            hop_reg        <= ble_dcs_pkg::HOP_RESET;
            cur_map_reg    <= ble_dcs_pkg::MAP_ALL;
            pend_map_reg   <= '0;
            pend_inst_reg  <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= ble_dcs_pkg::CNT_RESET;
            unm_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            hop_reg        <= hop_next;
            cur_map_reg    <= cur_map_next;
            pend_map_reg   <= pend_map_next;
            pend_inst_reg  <= pend_inst_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
            unm_reg        <= unm_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg   <= m_data_next;
        applied_reg  <= applied_next;
        idx_reg      <= idx_next;
        used_reg     <= used_next;
        hit_reg      <= hit_next;
        rem_reg      <= rem_next;
        dvd_reg      <= dvd_next;
        step_reg     <= step_next;
        seen_reg     <= seen_next;
        found_ch_reg <= found_ch_next;
        found_reg    <= found_next;
    end

    `ASSERT_PROP(a_unm_range, clk, rst_n, unm_reg < ble_dcs_pkg::NUM_CH_V)
    `ASSERT_PROP(a_rem_below_used, clk, rst_n, (state_reg == ble_dcs_pkg::ST_FIND) |-> (rem_reg < used_reg))
    `ASSERT_PROP(a_found_after_scan, clk, rst_n, ((state_reg == ble_dcs_pkg::ST_FIND) && scan_last) |=> found_reg)
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, out_load && m_valid_reg && !m_axis_tready)

endmodule

[bench/tb.sv]
// Self-checking testbench for the BLE data channel selection block.
module tb;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int HOLDOFF_CYCLES = 1500;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 75;
    localparam int DIRECTED_ROWS   = 21;

    typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pacing_t;

    typedef struct packed {
        logic [ble_dcs_pkg::CNT_W-1:0] event_counter;
        logic [ble_dcs_pkg::CH_W-1:0]  hop_channel;
        logic [ble_dcs_pkg::CH_W-1:0]  data_channel;
        logic                          map_applied;
        logic                          no_channel;
    } hop_result_t;

    typedef struct packed {
        logic [1:0]                    act;
        logic [ble_dcs_pkg::MAP_W-1:0] map;
        logic [ble_dcs_pkg::CNT_W-1:0] inst;
        logic                          pinned;
        hop_result_t                   want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = ble_dcs_pkg::ACT_ADVANCE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    // Result pinned by a directed row, travels beside the input word.
    logic        pin_use = 1'b0;
    hop_result_t pin_want = '0;

    pacing_t     pacing = PACE_NONE;
    int          holdoff_req = 0;
    int          holdoff_ack = 0;
    int          failures = 0;
    int          quiet_cycles = 0;

    // Predictor state, updated only at accepted input and config words.
    logic [ble_dcs_pkg::HOP_W-1:0] hop_step = ble_dcs_pkg::HOP_RESET;
    logic [ble_dcs_pkg::MAP_W-1:0] link_map = ble_dcs_pkg::MAP_ALL;
    logic [ble_dcs_pkg::MAP_W-1:0] queued_map = '0;
    logic [ble_dcs_pkg::CNT_W-1:0] queued_instant = '0;
    logic                          queued_valid = 1'b0;
    logic [ble_dcs_pkg::CNT_W-1:0] event_cnt = ble_dcs_pkg::CNT_RESET;
    logic [ble_dcs_pkg::CH_W-1:0]  unmapped_ch = '0;
    hop_result_t                   expected_hops[$];

    // Columns: action, map, instant, pinned, {counter, unmapped, data, applied, empty}.
    directed_row_t directed [DIRECTED_ROWS] = '{
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h0, 16'h0, 1'b1,
          '{16'd0, 6'd5, 6'd5, 1'b0, 1'b0}},
        '{ble_dcs_pkg::ACT_START, 37'h1f_ffff_ffff, 16'h0, 1'b1,
          '{16'd0, 6'd5, 6'd5, 1'b0, 1'b0}},
        '{ble_dcs_pkg::ACT_START, 37'h0, 16'hffff, 1'b1,
          '{16'd0, 6'd5, 6'd0, 1'b0, 1'b1}},
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h1f_ffff_ffff, 16'hffff, 1'b1,
          '{16'd1, 6'd10, 6'd0, 1'b0, 1'b1}},
        '{ble_dcs_pkg::ACT_QUEUE, 37'h1f_ffff_ffff, 16'd2, 1'b0, '0},
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h0, 16'h0, 1'b1,
          '{16'd2, 6'd15, 6'd15, 1'b1, 1'b0}},
        '{ble_dcs_pkg::ACT_START, 37'h1, 16'h0, 1'b1,
          '{16'd0, 6'd5, 6'd0, 1'b0, 1'b0}},
        '{ble_dcs_pkg::ACT_START, 37'h10_0000_0000, 16'h0, 1'b1,
          '{16'd0, 6'd5, 6'd36, 1'b0, 1'b0}},
        '{ble_dcs_pkg::ACT_QUEUE, 37'h05_5555_5555, 16'hffff, 1'b0, '0},
        '{ble_dcs_pkg::ACT_QUEUE, 37'h1a_aaaa_aaaa, 16'd3, 1'b0, '0},
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h0, 16'h0, 1'b0, '0},
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h0, 16'h0, 1'b0, '0},
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h0, 16'h0, 1'b0, '0},
        '{ble_dcs_pkg::ACT_QUEUE, 37'h0f_0f0f_0f0f, 16'd1, 1'b0, '0},
        '{ble_dcs_pkg::ACT_START, 37'h15_5555_5555, 16'h0, 1'b0, '0},
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h0, 16'h0, 1'b0, '0},
        '{ACT_RESERVED, 37'h1f_ffff_ffff, 16'hffff, 1'b0, '0},
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h0, 16'h0, 1'b0, '0},
        '{ble_dcs_pkg::ACT_QUEUE, 37'h0, 16'd3, 1'b0, '0},
        '{ble_dcs_pkg::ACT_ADVANCE, 37'h0, 16'h0, 1'b0, '0},
        '{ble_dcs_pkg::ACT_START, 37'h1f_ffff_ffff, 16'h0, 1'b0, '0}
    };

    ble_data_channel_select dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One connection event: step the counter, maybe switch maps, hop and remap.
    function automatic hop_result_t hop_once();
        hop_result_t r;
        int used;
        int want_rank;
        int seen;
        r = '0;
        event_cnt = event_cnt + 1'b1;
        if (queued_valid && queued_instant == event_cnt)
        begin
            link_map = queued_map;
            queued_valid = 1'b0;
            r.map_applied = 1'b1;
        end
        unmapped_ch = ble_dcs_pkg::CH_W'((int'(unmapped_ch) + int'(hop_step))
                      % ble_dcs_pkg::NUM_CH);
        used = $countones(link_map);
        if (used == 0)
            r.no_channel = 1'b1;
        else if (link_map[unmapped_ch])
            r.data_channel = unmapped_ch;
        else
        begin
            want_rank = int'(unmapped_ch) % used;
            seen = 0;
            for (int ch = 0; ch < ble_dcs_pkg::NUM_CH; ch++)
            begin
                if (link_map[ch])
                begin
                    if (seen == want_rank)
                        r.data_channel = ble_dcs_pkg::CH_W'(ch);
                    seen++;
                end
            end
        end
        r.event_counter = event_cnt;
        r.hop_channel = unmapped_ch;
        return r;
    endfunction

    task automatic take_word(input logic [1:0] act, input logic [55:0] data);
        hop_result_t r;
        r = '0;
        case (act)
            ble_dcs_pkg::ACT_QUEUE:
            begin
                queued_map = data[ble_dcs_pkg::MAP_W-1:0];
                queued_instant = data[ble_dcs_pkg::MAP_W +: ble_dcs_pkg::CNT_W];
                queued_valid = 1'b1;
            end
            ble_dcs_pkg::ACT_ADVANCE:
                r = hop_once();
            ble_dcs_pkg::ACT_START:
            begin
                link_map = data[ble_dcs_pkg::MAP_W-1:0];
                queued_valid = 1'b0;
                event_cnt = ble_dcs_pkg::CNT_RESET;
                unmapped_ch = '0;
                r = hop_once();
            end
            default: ;
        endcase
        if (act == ble_dcs_pkg::ACT_ADVANCE || act == ble_dcs_pkg::ACT_START)
            expected_hops.push_back(pin_use ? pin_want : r);
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            failures++;
        end
    endfunction

    task automatic check_result(input logic [31:0] word);
        hop_result_t want;
        if (expected_hops.size() == 0)
        begin
            $display("%0t: unexpected result word, expected none, got %h", $time, word);
            failures++;
        end
        else
        begin
            want = expected_hops.pop_front();
            check_field("event_counter", want.event_counter, word[15:0]);
            check_field("hop_channel", want.hop_channel, word[21:16]);
            check_field("data_channel", want.data_channel, word[27:22]);
            check_field("map_applied", want.map_applied, word[28]);
            check_field("no_channel", want.no_channel, word[29]);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                hop_step = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                take_word(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
        end
    end

    // Watchdog: cycles in a row with no word moving on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL ble_data_channel_select");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (holdoff_req != holdoff_ack)
            begin
                holdoff_ack = holdoff_req;
                m_axis_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(negedge clk);
            end
            if (pacing == PACE_RECV)
                m_axis_tready <= ($urandom_range(99) >= 57);
            else if (pacing == PACE_BOTH)
                m_axis_tready <= ($urandom_range(99) >= 20);
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic bit sender_gap();
        if (pacing == PACE_SEND)
            return $urandom_range(99) < 57;
        if (pacing == PACE_BOTH)
            return $urandom_range(99) < 20;
        return 1'b0;
    endfunction

    // Entered at a falling edge; returns at the rising edge that takes the word.
    task automatic send_word(input logic [1:0] act,
                             input logic [ble_dcs_pkg::MAP_W-1:0] map,
                             input logic [ble_dcs_pkg::CNT_W-1:0] inst,
                             input logic pinned,
                             input hop_result_t pinned_val);
        while (sender_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {3'b000, inst, map};
        pin_use <= pinned;
        pin_want <= pinned_val;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Returns at a falling edge once every result is in and the block has gone idle.
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_hops.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Entered at a falling edge with the block idle.
    task automatic write_hop(input logic [ble_dcs_pkg::HOP_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [ble_dcs_pkg::MAP_W-1:0] pick_map();
        logic [ble_dcs_pkg::MAP_W-1:0] m;
        int kind;
        kind = $urandom_range(99);
        m = {5'($urandom), 32'($urandom)};
        if (kind < 12)
            m = ble_dcs_pkg::MAP_ALL;
        else if (kind < 20)
            m = '0;
        else if (kind < 45)
        begin
            m = '0;
            repeat ($urandom_range(1, 3)) m[$urandom_range(ble_dcs_pkg::NUM_CH - 1)] = 1'b1;
        end
        return m;
    endfunction

    // Mostly advances, with map updates aimed a few events ahead so they land.
    task automatic pick_word(output logic [1:0] act,
                             output logic [ble_dcs_pkg::MAP_W-1:0] map,
                             output logic [ble_dcs_pkg::CNT_W-1:0] inst);
        int roll;
        roll = $urandom_range(99);
        map = pick_map();
        inst = ble_dcs_pkg::CNT_W'($urandom);
        if (roll < 12)
            act = ble_dcs_pkg::ACT_START;
        else if (roll < 30)
        begin
            act = ble_dcs_pkg::ACT_QUEUE;
            if ($urandom_range(9) < 8)
                inst = event_cnt + ble_dcs_pkg::CNT_W'($urandom_range(1, 4));
        end
        else if (roll < 97)
            act = ble_dcs_pkg::ACT_ADVANCE;
        else
            act = ACT_RESERVED;
    endtask

    function automatic logic [ble_dcs_pkg::HOP_W-1:0] hop_for_phase(input int p);
        case (p)
            0: return ble_dcs_pkg::HOP_W'(16);
            1: return ble_dcs_pkg::HOP_W'(0);
            2: return ble_dcs_pkg::HOP_W'(31);
            3: return ble_dcs_pkg::HOP_W'(5);
            default: return ble_dcs_pkg::HOP_W'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [1:0]                    act;
        logic [ble_dcs_pkg::MAP_W-1:0] map;
        logic [ble_dcs_pkg::CNT_W-1:0] inst;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            @(negedge clk);
            send_word(directed[i].act, directed[i].map, directed[i].inst,
                      directed[i].pinned, directed[i].want);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            pacing <= pacing_t'(p % 4);
            write_hop(hop_for_phase(p));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
            begin
                // Pause the sender right after the last accepted word.
                if (p == 1 && n == 30)
                    wait_drained();
                @(negedge clk);
                // Stop draining results for a while; the input side must back up.
                if (p == 0 && n == 20)
                    holdoff_req <= holdoff_req + 1;
                pick_word(act, map, inst);
                send_word(act, map, inst, 1'b0, '0);
            end
        end

        wait_drained();
        if (failures == 0)
            $display("PASS ble_data_channel_select");
        else
            $display("FAIL ble_data_channel_select");
        $finish;
    end

endmodule
